// ===== design/gfm_pkg.sv =====
// Shared types, constants and a carry-less helper for the GF(2^192) multiply/square unit.
package gfm_pkg;

	localparam int WORD_W   = 64;
	localparam int FIELD_W  = 192;
	localparam int HALF_W   = 32;
	localparam int NUM_HALF = FIELD_W / HALF_W;
	localparam int PP_W     = 2 * HALF_W - 1;
	localparam int PROD_W   = 2 * FIELD_W - 1;
	localparam int HI_W     = PROD_W - FIELD_W;
	localparam int FOLD_W   = 8;
	localparam int SPILL_W  = FOLD_W - 2;

	// x^192 = x^7 + x^2 + x + 1
	localparam logic [FOLD_W-1:0] FOLD_POLY = 8'h87;

	typedef enum logic [1:0] {
		CFG_MULT_LOW  = 2'd0,
		CFG_MULT_MID  = 2'd1,
		CFG_MULT_HIGH = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		ACT_SQUARE = 1'b0,
		ACT_MAC    = 1'b1
	} action_t;

	typedef struct packed {
		logic              action;
		logic [WORD_W-1:0] operand_low;
		logic [WORD_W-1:0] operand_mid;
		logic [WORD_W-1:0] operand_high;
		logic [WORD_W-1:0] acc_in_low;
		logic [WORD_W-1:0] acc_in_mid;
		logic [WORD_W-1:0] acc_in_high;
	} in_t;

	typedef struct packed {
		logic [WORD_W-1:0] result_low;
		logic [WORD_W-1:0] result_mid;
		logic [WORD_W-1:0] result_high;
	} out_t;

	typedef logic [PP_W-1:0] pp_t;

	// Carry-less 32x32 product.
	function automatic pp_t clmul32(input logic [HALF_W-1:0] a, input logic [HALF_W-1:0] b);
		pp_t acc;
		acc = '0;
		for (int i = 0; i < HALF_W; i++) begin
			if (b[i])
				acc = acc ^ (pp_t'(a) << i);
		end
		return acc;
	endfunction

endpackage

// ===== design/gfm_partial.sv =====
// Stage two: all 32x32 carry-less partial products of the two operands.
module gfm_partial
	import gfm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid_in,
	input  logic [FIELD_W-1:0]    a_in,
	input  logic [FIELD_W-1:0]    b_in,
	input  logic [FIELD_W-1:0]    acc_in,
	output logic                  valid_s2,
	output pp_t                   pp_s2 [NUM_HALF][NUM_HALF],
	output logic [FIELD_W-1:0]    acc_s2
);

	pp_t pp_d [NUM_HALF][NUM_HALF];

	always_comb begin
		for (int i = 0; i < NUM_HALF; i++) begin
			for (int j = 0; j < NUM_HALF; j++) begin
				pp_d[i][j] = clmul32(a_in[i*HALF_W +: HALF_W], b_in[j*HALF_W +: HALF_W]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s2  <= pp_d;
			acc_s2 <= acc_in;
		end
	end

endmodule

// ===== design/gfm_combine.sv =====
// Stage three: XOR the partial products into the 383-bit carry-less product.
module gfm_combine
	import gfm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid_in,
	input  pp_t                   pp_in [NUM_HALF][NUM_HALF],
	input  logic [FIELD_W-1:0]    acc_in,
	output logic                  valid_s3,
	output logic [PROD_W-1:0]     prod_s3,
	output logic [FIELD_W-1:0]    acc_s3
);

	logic [PROD_W-1:0] prod_d;

	always_comb begin
		prod_d = '0;
		for (int i = 0; i < NUM_HALF; i++) begin
			for (int j = 0; j < NUM_HALF; j++) begin
				prod_d[(i+j)*HALF_W +: PP_W] = prod_d[(i+j)*HALF_W +: PP_W] ^ pp_in[i][j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= prod_d;
			acc_s3  <= acc_in;
		end
	end

endmodule

// ===== design/gfm_reduce.sv =====
// Stage four: reduce the product modulo x^192+x^7+x^2+x+1 and add the accumulator.
module gfm_reduce
	import gfm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  valid_in,
	input  logic [PROD_W-1:0]     prod_in,
	input  logic [FIELD_W-1:0]    acc_in,
	output logic                  valid_s4,
	output out_t                  res_s4
);

	logic [HI_W-1:0]             hi;
	logic [HI_W+FOLD_W-2:0]      t;
	logic [SPILL_W-1:0]          spill;
	logic [SPILL_W+FOLD_W-2:0]   u;
	logic [FIELD_W-1:0]          r;

	always_comb begin
		hi = prod_in[PROD_W-1:FIELD_W];
		t  = '0;
		for (int k = 0; k < FOLD_W; k++) begin
			if (FOLD_POLY[k])
				t = t ^ ((HI_W+FOLD_W-1)'(hi) << k);
		end
		// bits past 191 after the first fold wrap around once more
		spill = t[HI_W+FOLD_W-2:FIELD_W];
		u     = '0;
		for (int k = 0; k < FOLD_W; k++) begin
			if (FOLD_POLY[k])
				u = u ^ ((SPILL_W+FOLD_W-1)'(spill) << k);
		end
		r = prod_in[FIELD_W-1:0] ^ t[FIELD_W-1:0] ^ FIELD_W'(u) ^ acc_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s4.result_low  <= r[0*WORD_W +: WORD_W];
			res_s4.result_mid  <= r[1*WORD_W +: WORD_W];
			res_s4.result_high <= r[2*WORD_W +: WORD_W];
		end
	end

endmodule

// ===== design/gf192_multiply_square.sv =====
// Top level of the pipelined GF(2^192) square / multiply-accumulate unit.
//
//   port group   dir   handshake             payload
//   in_*         in    in_valid / in_ready   in_data (in_t)
//   out_*        out   out_valid / out_ready out_data (out_t)
//   cfg_*        in    cfg_valid / cfg_ready cfg_index, cfg_data
//
// One request per cycle unless a stalled output fills the pipe. Stages:
// input register, partial products, product assembly, output reduction.
// Reset clears the valid bits and the multiplier registers.
// A stalled output holds the full run of stages behind it; the rest move on.
// Config writes are always taken (cfg_ready is tied high).
module gf192_multiply_square
	import gfm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_t                  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_t                 out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	logic [WORD_W-1:0]  mult_low_q, mult_mid_q, mult_high_q;

	logic               valid_s1;
	logic [FIELD_W-1:0] a_s1, b_s1, acc_s1;

	logic               valid_s2, valid_s3, valid_s4;
	pp_t                pp_s2 [NUM_HALF][NUM_HALF];
	logic [FIELD_W-1:0] acc_s2, acc_s3;
	logic [PROD_W-1:0]  prod_s3;
	out_t               res_s4;

	logic en1, en2, en3, en4;

	logic [FIELD_W-1:0] a_d, b_d, acc_d;
	logic               is_mac;

	// a stage advances when it is empty or the next one advances
	assign en4 = !valid_s4 || out_ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;

	assign in_ready  = en1;
	assign out_valid = valid_s4;
	assign out_data  = res_s4;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_low_q  <= '0;
			mult_mid_q  <= '0;
			mult_high_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MULT_LOW:  mult_low_q  <= cfg_data;
				CFG_MULT_MID:  mult_mid_q  <= cfg_data;
				CFG_MULT_HIGH: mult_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		is_mac = (in_data.action == ACT_MAC);
		a_d    = {in_data.operand_high, in_data.operand_mid, in_data.operand_low};
		b_d    = is_mac ? {mult_high_q, mult_mid_q, mult_low_q} : a_d;
		// squaring ignores the accumulator
		acc_d  = is_mac ? {in_data.acc_in_high, in_data.acc_in_mid, in_data.acc_in_low} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			a_s1   <= a_d;
			b_s1   <= b_d;
			acc_s1 <= acc_d;
		end
	end

	gfm_partial u_partial (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_in (valid_s1),
		.a_in     (a_s1),
		.b_in     (b_s1),
		.acc_in   (acc_s1),
		.valid_s2 (valid_s2),
		.pp_s2    (pp_s2),
		.acc_s2   (acc_s2)
	);

	gfm_combine u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en3),
		.valid_in (valid_s2),
		.pp_in    (pp_s2),
		.acc_in   (acc_s2),
		.valid_s3 (valid_s3),
		.prod_s3  (prod_s3),
		.acc_s3   (acc_s3)
	);

	gfm_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en4),
		.valid_in (valid_s3),
		.prod_in  (prod_s3),
		.acc_in   (acc_s3),
		.valid_s4 (valid_s4),
		.res_s4   (res_s4)
	);

endmodule

// ===== tb/gf192_multiply_square_tb.sv =====
// Testbench for the GF(2^192) square / multiply-accumulate unit.
`timescale 1ns / 1ps

module gf192_multiply_square_tb;
	import gfm_pkg::*;

	localparam int          CYCLE_LIMIT    = 200000;
	localparam int          ITEMS_PER_SET  = 150;
	localparam int          NUM_SETS       = 5;
	localparam int          HOLD_CYCLES    = 80;
	localparam logic [1:0]  CFG_IDX_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		STALL_NONE     = 2'd0,
		STALL_HALF     = 2'd1,
		STALL_HEAVY    = 2'd2,
		STALL_PERIODIC = 2'd3
	} stall_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	in_t                 in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_t                out_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [1:0]          cfg_index = '0;
	logic [WORD_W-1:0]   cfg_data  = '0;

	in_t                 req_q[$];
	out_t                field_results_q[$];
	logic [FIELD_W-1:0]  mult_shadow;
	int                  err_cnt;
	int                  cyc;
	int                  burst_left;
	int                  gap_left;
	int                  rx_cyc;
	int                  hold_left;

	gf192_multiply_square u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Full carry-less product, then clear bits 382..192 one at a time with the polynomial.
	function automatic logic [FIELD_W-1:0] gf_mul(input logic [FIELD_W-1:0] a,
			input logic [FIELD_W-1:0] b);
		logic [2*FIELD_W-1:0] p;
		p = '0;
		for (int i = 0; i < FIELD_W; i++) begin
			if (b[i])
				p = p ^ ((2*FIELD_W)'(a) << i);
		end
		for (int i = 2*FIELD_W-2; i >= FIELD_W; i--) begin
			if (p[i]) begin
				p[i] = 1'b0;
				p = p ^ ((2*FIELD_W)'(FOLD_POLY) << (i - FIELD_W));
			end
		end
		return p[FIELD_W-1:0];
	endfunction

	function automatic out_t field_result(input in_t req, input logic [FIELD_W-1:0] mult);
		logic [FIELD_W-1:0] op;
		logic [FIELD_W-1:0] r;
		out_t res;
		op = {req.operand_high, req.operand_mid, req.operand_low};
		if (action_t'(req.action) == ACT_SQUARE)
			r = gf_mul(op, op);
		else
			r = gf_mul(op, mult) ^ {req.acc_in_high, req.acc_in_mid, req.acc_in_low};
		res.result_low  = r[63:0];
		res.result_mid  = r[127:64];
		res.result_high = r[191:128];
		return res;
	endfunction

	function automatic in_t make_req(input action_t act, input logic [FIELD_W-1:0] op,
			input logic [FIELD_W-1:0] acc);
		in_t req;
		req.action       = act;
		req.operand_low  = op[63:0];
		req.operand_mid  = op[127:64];
		req.operand_high = op[191:128];
		req.acc_in_low   = acc[63:0];
		req.acc_in_mid   = acc[127:64];
		req.acc_in_high  = acc[191:128];
		return req;
	endfunction

	// Mostly random words, with zeros, all-ones and single bits mixed in.
	function automatic logic [WORD_W-1:0] rand_word();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0:       return '0;
			1:       return '1;
			2:       return 64'd1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [FIELD_W-1:0] rand_elem();
		return {rand_word(), rand_word(), rand_word()};
	endfunction

	task automatic check_field(input string name, input logic [WORD_W-1:0] exp,
			input logic [WORD_W-1:0] act);
		if (exp !== act) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("mismatch %s: expected %h got %h", name, exp, act);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
	endtask

	task automatic set_multiplier(input logic [FIELD_W-1:0] m);
		write_reg(CFG_MULT_LOW,  m[63:0]);
		write_reg(CFG_MULT_MID,  m[127:64]);
		write_reg(CFG_MULT_HIGH, m[191:128]);
	endtask

	// Sample on the falling edge so the sender and checker have settled.
	task automatic wait_idle();
		while (req_q.size() != 0 || in_valid || field_results_q.size() != 0)
			@(negedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (req_q.size() != 0) begin
				in_data  <= req_q.pop_front();
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: rotating stall pattern plus a periodic long hold to back up the pipeline.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cyc    <= 0;
			hold_left <= 0;
		end else begin
			rx_cyc <= rx_cyc + 1;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (rx_cyc % 1000 == 300) begin
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				case (stall_t'(rx_cyc[8:7]))
					STALL_NONE:     out_ready <= 1'b1;
					STALL_HALF:     out_ready <= ($urandom_range(0, 1) == 0);
					STALL_HEAVY:    out_ready <= ($urandom_range(0, 3) == 0);
					STALL_PERIODIC: out_ready <= rx_cyc[1] ^ rx_cyc[3];
				endcase
			end
		end
	end

	// Track the multiplier, predict each accepted request, check each accepted result.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MULT_LOW:  mult_shadow[63:0]    = cfg_data;
					CFG_MULT_MID:  mult_shadow[127:64]  = cfg_data;
					CFG_MULT_HIGH: mult_shadow[191:128] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				field_results_q.push_back(field_result(in_data, mult_shadow));
			if (out_valid && out_ready) begin
				if (field_results_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected result: got %h", out_data);
				end else begin
					out_t exp;
					exp = field_results_q.pop_front();
					check_field("result_low",  exp.result_low,  out_data.result_low);
					check_field("result_mid",  exp.result_mid,  out_data.result_mid);
					check_field("result_high", exp.result_high, out_data.result_high);
				end
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cyc);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [FIELD_W-1:0] ones;
		logic [FIELD_W-1:0] m;
		ones        = '1;
		mult_shadow = '0;
		err_cnt     = 0;
		cyc         = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Multiplier still at reset (zero): multiply-accumulate passes the accumulator.
		req_q.push_back(make_req(ACT_SQUARE, '0, '0));
		req_q.push_back(make_req(ACT_SQUARE, 192'd1, ones));
		req_q.push_back(make_req(ACT_SQUARE, ones, ones));
		req_q.push_back(make_req(ACT_SQUARE, 192'd1 << 191, '0));
		req_q.push_back(make_req(ACT_SQUARE, 192'd1 << 96, '0));
		req_q.push_back(make_req(ACT_SQUARE, 192'd1 << 64, '0));
		req_q.push_back(make_req(ACT_SQUARE, 192'd1 << 128, ones));
		req_q.push_back(make_req(ACT_MAC, ones, ones));
		req_q.push_back(make_req(ACT_MAC, ones, '0));
		req_q.push_back(make_req(ACT_MAC, 192'd1, {64'h0123456789abcdef, 64'h0, 64'h1}));
		wait_idle();

		// Multiplier one, with an ignored write to the spare index in between.
		set_multiplier(192'd1);
		write_reg(CFG_IDX_UNUSED, '1);
		req_q.push_back(make_req(ACT_MAC, ones, ones));
		req_q.push_back(make_req(ACT_MAC, ones, '0));
		req_q.push_back(make_req(ACT_MAC, 192'd1 << 191, '0));
		req_q.push_back(make_req(ACT_MAC, '0, ones));
		req_q.push_back(make_req(ACT_SQUARE, ones, '0));
		wait_idle();

		// Multiplier all ones against the extremes.
		set_multiplier(ones);
		req_q.push_back(make_req(ACT_MAC, ones, '0));
		req_q.push_back(make_req(ACT_MAC, ones, ones));
		req_q.push_back(make_req(ACT_MAC, 192'd1 << 191, '0));
		req_q.push_back(make_req(ACT_MAC, '0, '0));
		req_q.push_back(make_req(ACT_SQUARE, 192'd1 << 191, ones));
		wait_idle();

		for (int s = 0; s < NUM_SETS; s++) begin
			case (s)
				0:       m = ones;
				1:       m = 192'd1 << 191;
				3:       m = '0;
				default: m = rand_elem();
			endcase
			set_multiplier(m);
			if (s == 4)
				write_reg(CFG_IDX_UNUSED, rand_word());
			for (int i = 0; i < ITEMS_PER_SET; i++)
				req_q.push_back(make_req(action_t'($urandom_range(0, 1)),
					rand_elem(), rand_elem()));
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (field_results_q.size() != 0) begin
			err_cnt++;
			$display("%0d results never arrived", field_results_q.size());
		end
		if (err_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
